/* src/srs_pkg.sv */
package srs_pkg;

  localparam int StackDepth = 32;
  localparam int PtrW       = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int PairCount  = 34;
  localparam int PairW      = $clog2(PairCount);
  localparam int CpW        = 21;
  localparam int ScriptW    = 8;
  localparam int BcW        = 3;
  localparam int PosW       = 32;

  // scripts at or below this code join any run
  localparam logic [ScriptW-1:0] ScriptInherited = 8'd1;

  // bracket pairs: even index opens, odd index closes
  localparam logic [CpW-1:0] PairTab [PairCount] = '{
    21'h0028, 21'h0029, 21'h003c, 21'h003e, 21'h005b, 21'h005d, 21'h007b, 21'h007d,
    21'h00ab, 21'h00bb, 21'h2018, 21'h2019, 21'h201c, 21'h201d, 21'h2039, 21'h203a,
    21'h3008, 21'h3009, 21'h300a, 21'h300b, 21'h300c, 21'h300d, 21'h300e, 21'h300f,
    21'h3010, 21'h3011, 21'h3014, 21'h3015, 21'h3016, 21'h3017, 21'h3018, 21'h3019,
    21'h301a, 21'h301b
  };

  typedef struct packed {
    logic               valid;
    logic [PosW-1:0]    start;
    logic [PosW-1:0]    limit;
    logic [ScriptW-1:0] script;
    logic               final_run;
  } emit_t;

  typedef struct packed {
    logic               pair_we;
    logic               script_we;
    logic [PtrW-1:0]    waddr;
    logic [PairW-1:0]   pair_wdata;
    logic [ScriptW-1:0] script_wdata;
    logic [PtrW-1:0]    raddr;
  } stk_req_t;

  // returns {found, index}
  function automatic logic [PairW:0] pair_lookup(input logic [CpW-1:0] cp);
    logic [PairW:0] res;
    res = '0;
    for (int i = 0; i < PairCount; i++) begin
      if (PairTab[i] == cp) begin
        res = {1'b1, PairW'(i)};
      end
    end
    return res;
  endfunction

endpackage

/* src/srs_ram.sv */
module srs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/srs_ctrl.sv */
module srs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [srs_pkg::CpW-1:0]       code_point_i,
  input  logic [srs_pkg::ScriptW-1:0]   char_script_i,
  input  logic [srs_pkg::BcW-1:0]       byte_count_i,
  input  logic                          last_char_i,
  input  logic                          out_free_i,
  output srs_pkg::emit_t                emit_o,
  output srs_pkg::stk_req_t             req_o,
  input  logic [srs_pkg::PairW-1:0]     rd_pair_i,
  input  logic [srs_pkg::ScriptW-1:0]   rd_script_i
);
  import srs_pkg::*;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StTake    = 4'd1;
  localparam logic [3:0] StSrch    = 4'd2;
  localparam logic [3:0] StCmp     = 4'd3;
  localparam logic [3:0] StJoin    = 4'd4;
  localparam logic [3:0] StFix     = 4'd5;
  localparam logic [3:0] StFin     = 4'd6;
  localparam logic [3:0] StEmitBrk = 4'd7;
  localparam logic [3:0] StEmitEnd = 4'd8;

  localparam logic [PtrW-1:0] PtrEmpty = PtrW'(StackDepth - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(StackDepth);

  logic [3:0]         state_q, state_d;
  logic               found_q, found_d;
  logic [PairW-1:0]   pi_q, pi_d;
  logic [ScriptW-1:0] sc_q, sc_d;
  logic [ScriptW-1:0] sce_q, sce_d;
  logic [BcW-1:0]     bc_q, bc_d;
  logic               last_q, last_d;
  logic [PtrW-1:0]    top_q, top_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    pend_q, pend_d;
  logic [ScriptW-1:0] rs_q, rs_d;
  logic [PosW-1:0]    start_q, start_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PtrW-1:0]    fix_idx_q, fix_idx_d;

  logic [PairW:0]     lookup;
  logic               closing;
  logic               joins;
  logic [PtrW-1:0]    top_inc;
  logic [PtrW-1:0]    top_dec;
  logic [PtrW-1:0]    fix_inc;
  logic [CntW:0]      fix_sum;
  logic [PtrW-1:0]    fix_first;

  assign lookup  = pair_lookup(code_point_i);
  assign closing = found_q && pi_q[0];
  assign joins   = (rs_q <= ScriptInherited) || (sce_q <= ScriptInherited) || (rs_q == sce_q);
  assign top_inc = (top_q == PtrEmpty) ? '0 : top_q + PtrW'(1);
  assign top_dec = (top_q == '0) ? PtrEmpty : top_q - PtrW'(1);
  assign fix_inc = (fix_idx_q == PtrEmpty) ? '0 : fix_idx_q + PtrW'(1);
  // first pending entry: top - pending + 1, kept at or below twice the depth
  assign fix_sum = (CntW+1)'(top_q) + (CntW+1)'(StackDepth) - (CntW+1)'(pend_q)
                 + (CntW+1)'(1);
  assign fix_first = (fix_sum >= (CntW+1)'(StackDepth))
                   ? PtrW'(fix_sum - (CntW+1)'(StackDepth)) : PtrW'(fix_sum);

  always_comb begin
    state_d   = state_q;
    found_d   = found_q;
    pi_d      = pi_q;
    sc_d      = sc_q;
    sce_d     = sce_q;
    bc_d      = bc_q;
    last_d    = last_q;
    top_d     = top_q;
    count_d   = count_q;
    pend_d    = pend_q;
    rs_d      = rs_q;
    start_d   = start_q;
    pos_d     = pos_q;
    fix_idx_d = fix_idx_q;

    in_ready_o = 1'b0;
    emit_o     = '0;
    req_o      = '0;
    req_o.raddr = top_q;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          found_d = lookup[PairW];
          pi_d    = lookup[PairW-1:0];
          sc_d    = char_script_i;
          bc_d    = byte_count_i;
          last_d  = last_char_i;
          state_d = StTake;
        end
      end
      StTake: begin
        sce_d = sc_q;
        if (found_q && !pi_q[0]) begin
          // push opener with the run script it was seen in
          req_o.pair_we      = 1'b1;
          req_o.script_we    = 1'b1;
          req_o.waddr        = top_inc;
          req_o.pair_wdata   = pi_q;
          req_o.script_wdata = rs_q;
          top_d = top_inc;
          if (count_q < CntFull) count_d = count_q + CntW'(1);
          if (pend_q < CntFull) pend_d = pend_q + CntW'(1);
          state_d = StJoin;
        end else if (closing) begin
          state_d = StSrch;
        end else begin
          state_d = StJoin;
        end
      end
      StSrch: begin
        state_d = (count_q == '0) ? StJoin : StCmp;
      end
      StCmp: begin
        if (rd_pair_i != {pi_q[PairW-1:1], 1'b0}) begin
          count_d = count_q - CntW'(1);
          top_d   = (count_q == CntW'(1)) ? PtrEmpty : top_dec;
          if (pend_q != '0) pend_d = pend_q - CntW'(1);
          state_d = StSrch;
        end else begin
          sce_d   = rd_script_i;
          state_d = StJoin;
        end
      end
      StJoin: begin
        if (joins) begin
          state_d = StFin;
          if (rs_q <= ScriptInherited && sce_q > ScriptInherited) begin
            rs_d      = sce_q;
            fix_idx_d = fix_first;
            if (pend_q != '0) state_d = StFix;
          end
        end else begin
          state_d = StEmitBrk;
        end
      end
      StFix: begin
        req_o.script_we    = 1'b1;
        req_o.waddr        = fix_idx_q;
        req_o.script_wdata = rs_q;
        fix_idx_d = fix_inc;
        pend_d    = pend_q - CntW'(1);
        if (pend_q == CntW'(1)) state_d = StFin;
      end
      StFin: begin
        if (closing && count_q != '0) begin
          count_d = count_q - CntW'(1);
          top_d   = (count_q == CntW'(1)) ? PtrEmpty : top_dec;
          if (pend_q != '0) pend_d = pend_q - CntW'(1);
        end
        pos_d   = pos_q + PosW'(bc_q);
        state_d = last_q ? StEmitEnd : StIdle;
      end
      StEmitBrk: begin
        if (out_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.start     = start_q;
          emit_o.limit     = pos_q;
          emit_o.script    = rs_q;
          emit_o.final_run = 1'b0;
          start_d = pos_q;
          rs_d    = '0;
          pend_d  = '0;
          state_d = StTake;
        end
      end
      StEmitEnd: begin
        if (out_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.start     = start_q;
          emit_o.limit     = pos_q;
          emit_o.script    = rs_q;
          emit_o.final_run = 1'b1;
          top_d   = PtrEmpty;
          count_d = '0;
          pend_d  = '0;
          rs_d    = '0;
          start_d = '0;
          pos_d   = '0;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      top_q   <= PtrEmpty;
      count_q <= '0;
      pend_q  <= '0;
      rs_q    <= '0;
      start_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      rs_q    <= rs_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q   <= found_d;
    pi_q      <= pi_d;
    sc_q      <= sc_d;
    sce_q     <= sce_d;
    bc_q      <= bc_d;
    last_q    <= last_d;
    fix_idx_q <= fix_idx_d;
  end

  a_pend_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= count_q) else $error("pending fixups exceed stack fill");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> top_q == PtrEmpty) else $error("empty stack with live top");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> out_free_i) else $error("run emitted into a busy output");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid && emit_o.final_run |=> pos_q == '0 && count_q == '0 && rs_q == '0)
    else $error("state not cleared after final run");

endmodule

/* src/script_run_segmenter.sv */
// script run segmenter
// input channel: one decoded character per transfer (code point, script code from
// an outside property lookup, utf-8 byte count, last-character flag)
// output channel: one finished run per transfer (start and limit byte offsets,
// script, final-run flag); a character yields zero, one or two runs
// sequencing: a plain character walks accept, classify, join test and commit
// before the block is ready again, one step per sequencer state
// a closing bracket examines stack entries in turn (ram read at the top, then
// compare and pop), with one more search step when the stack is or runs empty
// a run script that first appears adds a fixup step per pending stack entry, as
// the script ram takes one write a cycle
// a run break adds an emit step and a second pass of the character; the last
// character adds an emit step
// results leave through a one-entry output register; while it is full and the
// receiver stalls, the sequencer waits in its emit step, so in_ready_o stays low
// reset: run state and stack pointers go to empty, the stack rams are not cleared
// (an entry is read only after it was pushed); after the final run the block
// returns to the same state by itself
module script_run_segmenter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [srs_pkg::CpW-1:0]     code_point_i,
  input  logic [srs_pkg::ScriptW-1:0] char_script_i,
  input  logic [srs_pkg::BcW-1:0]     byte_count_i,
  input  logic                        last_char_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [srs_pkg::PosW-1:0]    run_start_o,
  output logic [srs_pkg::PosW-1:0]    run_limit_o,
  output logic [srs_pkg::ScriptW-1:0] run_script_o,
  output logic                        final_run_o
);
  import srs_pkg::*;

  emit_t              emit;
  stk_req_t           req;
  logic [PairW-1:0]   rd_pair;
  logic [ScriptW-1:0] rd_script;
  logic               out_free;

  // output register holds one run
  logic               out_valid_q;
  logic [PosW-1:0]    out_start_q;
  logic [PosW-1:0]    out_limit_q;
  logic [ScriptW-1:0] out_script_q;
  logic               out_final_q;

  // a new run may load when the register is empty or drains this cycle
  assign out_free = !out_valid_q || out_ready_i;

  srs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_point_i  (code_point_i),
    .char_script_i (char_script_i),
    .byte_count_i  (byte_count_i),
    .last_char_i   (last_char_i),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .req_o         (req),
    .rd_pair_i     (rd_pair),
    .rd_script_i   (rd_script)
  );

  // bracket stack: pair index and script live in separate rams so a script
  // fixup rewrites one field only
  srs_ram #(.Width(PairW), .Depth(StackDepth)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (req.pair_we),
    .waddr_i (req.waddr),
    .wdata_i (req.pair_wdata),
    .raddr_i (req.raddr),
    .rdata_o (rd_pair)
  );

  srs_ram #(.Width(ScriptW), .Depth(StackDepth)) u_script_ram (
    .clk_i   (clk_i),
    .we_i    (req.script_we),
    .waddr_i (req.waddr),
    .wdata_i (req.script_wdata),
    .raddr_i (req.raddr),
    .rdata_o (rd_script)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_start_q  <= emit.start;
      out_limit_q  <= emit.limit;
      out_script_q <= emit.script;
      out_final_q  <= emit.final_run;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign run_start_o  = out_start_q;
  assign run_limit_o  = out_limit_q;
  assign run_script_o = out_script_q;
  assign final_run_o  = out_final_q;

endmodule
